/* src/lrss_pkg.sv */
// lrss_pkg: widths, word types and sequencer states for the log-rank split statistic unit
// no dependencies; imported by log_rank_split_statistic_unit and lrss_checker
`timescale 1ns / 1ps
`default_nettype none

package lrss_pkg;

    // count and fixed-point widths
    localparam int COUNT_BITS = 12;
    localparam int FRAC_BITS  = 16;

    // state and result widths
    localparam int NUM_W    = 32;
    localparam int VAR_W    = 40;
    localparam int STAT_W   = 32;
    localparam int OUT_FRAC = 16;

    // multiplier operand and product widths
    localparam int HALF_W = 2 * COUNT_BITS;
    localparam int PROD_W = 4 * COUNT_BITS;
    localparam int DEN_W  = 3 * COUNT_BITS;

    // quotient bits of the numerator and variance divisions, root bits
    localparam int NQ_W   = 2 * COUNT_BITS + FRAC_BITS;
    localparam int VSHIFT = COUNT_BITS - 2;
    localparam int VQ_W   = VSHIFT + FRAC_BITS;
    localparam int RT_W   = (VAR_W + FRAC_BITS + 1) / 2;

    // shared radix-2 unit widths
    localparam int DIV_W  = (DEN_W > RT_W) ? DEN_W : RT_W;
    localparam int REM_W  = (DEN_W > RT_W + 1) ? DEN_W : RT_W + 1;
    localparam int ALU_W  = REM_W + 2;
    localparam int QA_W   = (NQ_W > STAT_W) ? NQ_W : STAT_W;
    localparam int Q_W    = (QA_W > RT_W) ? QA_W : RT_W;
    localparam int DVA_W  = (NQ_W > 2 * RT_W) ? NQ_W : 2 * RT_W;
    localparam int DVD_W  = (DVA_W > STAT_W) ? DVA_W : STAT_W;
    localparam int CNT_W  = $clog2(DVD_W + 1);

    // numerator accumulate width, wide enough for the sum plus the observed and expected terms
    localparam int SUMA_W = (NQ_W > NUM_W) ? NQ_W : NUM_W;
    localparam int SUM_W  = SUMA_W + 2;

    localparam logic [NUM_W-1:0] NUM_MAX = {1'b0, {(NUM_W-1){1'b1}}};
    localparam logic [NUM_W-1:0] NUM_MIN = {1'b1, {(NUM_W-1){1'b0}}};

    typedef struct packed {
        logic [COUNT_BITS-1:0] left_events;
        logic [COUNT_BITS-1:0] left_at_risk;
        logic [COUNT_BITS-1:0] parent_events;
        logic [COUNT_BITS-1:0] parent_at_risk;
        logic                  last_time;
    } t_in_word;

    typedef struct packed {
        logic [STAT_W-1:0] statistic;
        logic              saturated;
    } t_out_word;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_ND,
        ST_LD_NUM,
        ST_DIV_NUM,
        ST_ACC_NUM,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_AB,
        ST_MUL_NN,
        ST_MUL_DEN,
        ST_LD_VAR,
        ST_DIV_VAR,
        ST_ACC_VAR,
        ST_LD_SQRT,
        ST_SQRT,
        ST_CMP,
        ST_DIV_OUT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

/* src/log_rank_split_statistic_unit.sv */
// log_rank_split_statistic_unit: log-rank split statistic over a stream of event-time words
// depends on lrss_pkg (widths, word types, sequencer states)
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  signals                              word
// -------   ---------  -----------------------------------  ----------
// in        sink       i_in_valid / o_in_ready / i_in_data   t_in_word
// out       source     o_out_valid / i_out_ready / o_out_data t_out_word
//
// one word at a time; the shared radix-2 divide / square-root unit sets the pace
// a word with parent_at_risk of zero adds no term, one adds only the numerator term,
//   and two or more add both the numerator and the variance terms
// a word marked last then adds the square root, the compare and, unless zero or saturated, the final division
// reset (synchronous, active low) clears both sums, the sequencer and the output valid
// a finished result waits in the output register; the next word is taken meanwhile,
//   and only a second result stalls in ST_DONE until the first is taken
module log_rank_split_statistic_unit import lrss_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    // control registers
    t_state                  r_state, n_state;
    logic                    r_out_valid, n_out_valid;
    logic signed [NUM_W-1:0] r_num, n_num;
    logic [VAR_W-1:0]        r_var, n_var;

    // payload registers
    t_in_word            r_in, n_in;
    t_out_word           r_out, n_out;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [HALF_W-1:0]   r_a, n_a;
    logic [HALF_W-1:0]   r_b, n_b;
    logic [DEN_W-1:0]    r_den, n_den;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [DVD_W-1:0]    r_dvd, n_dvd;
    logic [DIV_W-1:0]    r_div, n_div;
    logic [Q_W-1:0]      r_q, n_q;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [STAT_W-1:0]   r_stat, n_stat;
    logic                r_sat, n_sat;

    // counts of the word in work, and the clamped ones for the variance term
    logic [COUNT_BITS-1:0] np, nl_c, dp_c;

    // shared multiplier
    logic [HALF_W-1:0] mul_x, mul_y;
    logic [PROD_W-1:0] mul_p;

    // shared subtract / compare
    logic [REM_W:0]   rem_sh1;
    logic [ALU_W-1:0] rem_sh2;
    logic [RT_W-1:0]  root;
    logic [ALU_W-1:0] alu_a, alu_b;
    logic [ALU_W:0]   alu_d;
    logic             alu_ge;
    logic             step_en;

    // accumulators
    logic [NUM_W-1:0]        n_abs;
    logic signed [SUM_W-1:0] num_ext, obs_ext, exp_ext, num_sum;
    logic [NUM_W-1:0]        num_sat;
    logic [VAR_W:0]          var_sum;
    logic [VAR_W-1:0]        var_sat;

    assign np   = r_in.parent_at_risk;
    assign nl_c = (r_in.left_at_risk > np) ? np : r_in.left_at_risk;
    assign dp_c = (r_in.parent_events > np) ? np : r_in.parent_events;

    // one multiplication per cycle, product registered before the next one reads it
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (r_state)
            ST_MUL_ND: begin
                mul_x = HALF_W'(r_in.left_at_risk);
                mul_y = HALF_W'(r_in.parent_events);
            end
            ST_MUL_A: begin
                mul_x = HALF_W'(nl_c);
                mul_y = HALF_W'(np - nl_c);
            end
            ST_MUL_B: begin
                mul_x = HALF_W'(np - dp_c);
                mul_y = HALF_W'(dp_c);
            end
            ST_MUL_AB: begin
                mul_x = r_a;
                mul_y = r_b;
            end
            ST_MUL_NN: begin
                mul_x = HALF_W'(np);
                mul_y = HALF_W'(np);
            end
            ST_MUL_DEN: begin
                mul_x = r_a;
                mul_y = HALF_W'(np - COUNT_BITS'(1));
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

    // radix-2 step: division brings in one dividend bit, square root two
    assign rem_sh1 = {r_rem, r_dvd[DVD_W-1]};
    assign rem_sh2 = {r_rem, r_dvd[DVD_W-1 -: 2]};
    assign root    = r_q[RT_W-1:0];
    assign n_abs   = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);

    always_comb begin
        case (r_state)
            ST_SQRT: begin
                alu_a = rem_sh2;
                alu_b = ALU_W'({root, 2'b01});
            end
            ST_CMP: begin
                // quotient overflows 32 bits exactly when the upper half of |num| >= root
                alu_a = ALU_W'(n_abs[NUM_W-1:OUT_FRAC]);
                alu_b = ALU_W'(root);
            end
            default: begin
                alu_a = ALU_W'(rem_sh1);
                alu_b = ALU_W'(r_div);
            end
        endcase
    end

    assign alu_d  = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_ge = ~alu_d[ALU_W];

    assign step_en = (r_state inside {ST_DIV_NUM, ST_DIV_VAR, ST_SQRT, ST_DIV_OUT});

    // numerator: add dL*2^F minus the expected count, clamp to signed 32 bits
    assign num_ext = {{(SUM_W-NUM_W){r_num[NUM_W-1]}}, r_num};
    assign obs_ext = SUM_W'({r_in.left_events, {FRAC_BITS{1'b0}}});
    assign exp_ext = SUM_W'(r_q[NQ_W-1:0]);
    assign num_sum = num_ext + obs_ext - exp_ext;

    always_comb begin
        if ((&num_sum[SUM_W-1:NUM_W-1]) || !(|num_sum[SUM_W-1:NUM_W-1])) begin
            num_sat = num_sum[NUM_W-1:0];
        end else if (num_sum[SUM_W-1]) begin
            num_sat = NUM_MIN;
        end else begin
            num_sat = NUM_MAX;
        end
    end

    // variance: unsigned add, clamp at all ones
    assign var_sum = {1'b0, r_var} + (VAR_W+1)'(r_q[VQ_W-1:0]);
    assign var_sat = var_sum[VAR_W] ? {VAR_W{1'b1}} : var_sum[VAR_W-1:0];

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_num       = r_num;
        n_var       = r_var;
        n_in        = r_in;
        n_out       = r_out;
        n_prod      = r_prod;
        n_a         = r_a;
        n_b         = r_b;
        n_den       = r_den;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_div       = r_div;
        n_q         = r_q;
        n_cnt       = r_cnt;
        n_stat      = r_stat;
        n_sat       = r_sat;

        if (step_en) begin
            n_rem = alu_ge ? alu_d[REM_W-1:0] : alu_a[REM_W-1:0];
            n_q   = {r_q[Q_W-2:0], alu_ge};
            n_dvd = (r_state == ST_SQRT) ? (r_dvd << 2) : (r_dvd << 1);
            n_cnt = r_cnt - CNT_W'(1);
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_in = i_in_data;
                    if (i_in_data.parent_at_risk != '0) begin
                        n_state = ST_MUL_ND;
                    end else if (i_in_data.last_time) begin
                        n_state = ST_LD_SQRT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_MUL_ND: begin
                n_prod  = mul_p;
                n_state = ST_LD_NUM;
            end
            ST_LD_NUM: begin
                // floor(nL*dP*2^F / nP)
                n_rem   = '0;
                n_q     = '0;
                n_dvd   = DVD_W'(r_prod[HALF_W-1:0]) << (DVD_W - HALF_W);
                n_div   = DIV_W'(np);
                n_cnt   = CNT_W'(NQ_W);
                n_state = ST_DIV_NUM;
            end
            ST_DIV_NUM: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_ACC_NUM;
                end
            end
            ST_ACC_NUM: begin
                n_num = num_sat;
                if (np > COUNT_BITS'(1)) begin
                    n_state = ST_MUL_A;
                end else if (r_in.last_time) begin
                    n_state = ST_LD_SQRT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL_A: begin
                n_a     = HALF_W'(mul_p);
                n_state = ST_MUL_B;
            end
            ST_MUL_B: begin
                n_b     = HALF_W'(mul_p);
                n_state = ST_MUL_AB;
            end
            ST_MUL_AB: begin
                n_prod  = mul_p;
                n_state = ST_MUL_NN;
            end
            ST_MUL_NN: begin
                n_a     = HALF_W'(mul_p);
                n_state = ST_MUL_DEN;
            end
            ST_MUL_DEN: begin
                n_den   = DEN_W'(mul_p);
                n_state = ST_LD_VAR;
            end
            ST_LD_VAR: begin
                // integer part of the variance term stays under 2^VSHIFT,
                // so the top bits start as the remainder
                n_rem   = REM_W'(r_prod >> VSHIFT);
                n_q     = '0;
                n_dvd   = DVD_W'(r_prod[VSHIFT-1:0]) << (DVD_W - VSHIFT);
                n_div   = DIV_W'(r_den);
                n_cnt   = CNT_W'(VQ_W);
                n_state = ST_DIV_VAR;
            end
            ST_DIV_VAR: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_ACC_VAR;
                end
            end
            ST_ACC_VAR: begin
                n_var   = var_sat;
                n_state = r_in.last_time ? ST_LD_SQRT : ST_IDLE;
            end
            ST_LD_SQRT: begin
                // var << F, left-aligned on an even bit boundary
                n_rem   = '0;
                n_q     = '0;
                n_dvd   = DVD_W'(r_var) << (DVD_W - 2 * RT_W + FRAC_BITS);
                n_cnt   = CNT_W'(RT_W);
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (n_abs == '0) begin
                    n_stat  = '0;
                    n_sat   = 1'b0;
                    n_state = ST_DONE;
                end else if (alu_ge) begin
                    // zero root lands here as well
                    n_stat  = {STAT_W{1'b1}};
                    n_sat   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_rem   = REM_W'(n_abs[NUM_W-1:OUT_FRAC]);
                    n_q     = '0;
                    n_dvd   = DVD_W'(n_abs[OUT_FRAC-1:0]) << (DVD_W - OUT_FRAC);
                    n_div   = DIV_W'(root);
                    n_cnt   = CNT_W'(STAT_W);
                    n_state = ST_DIV_OUT;
                end
            end
            ST_DIV_OUT: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_stat  = n_q[STAT_W-1:0];
                    n_sat   = 1'b0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid     = 1'b1;
                    n_out.statistic = r_stat;
                    n_out.saturated = r_sat;
                    n_num           = '0;
                    n_var           = '0;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_num       <= '0;
            r_var       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_num       <= n_num;
            r_var       <= n_var;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_out  <= n_out;
        r_prod <= n_prod;
        r_a    <= n_a;
        r_b    <= n_b;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_div  <= n_div;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
        r_stat <= n_stat;
        r_sat  <= n_sat;
    end

endmodule

`default_nettype wire

/* src/lrss_checker.sv */
// lrss_checker: port-level assertions for log_rank_split_statistic_unit, bound to it below
// depends on lrss_pkg (t_out_word)
`timescale 1ns / 1ps
`default_nettype none

module lrss_checker import lrss_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_data
);

    // stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    // stalled result word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result word changed while stalled");

    // a saturated result always carries the full-scale statistic
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.saturated || (&o_out_data.statistic)))
        else $error("saturated flag without full-scale statistic");

    // reset leaves no result word pending
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word pending after reset");

endmodule

bind log_rank_split_statistic_unit lrss_checker u_lrss_checker (.*);

`default_nettype wire
